// ----- hdl/cnv_pkg.sv -----
// Shared types, codes and constants for the 3x3 same-padding int8 convolution block.
// No dependencies; every other file of the block refers to it by scoped names.
package cnv_pkg;

   // Default sizes for the top-level parameters
   localparam int DEF_MAX_HEIGHT       = 32;
   localparam int DEF_MAX_WIDTH        = 32;
   localparam int DEF_MAX_IN_CHANNELS  = 16;
   localparam int DEF_MAX_OUT_CHANNELS = 16;

   // Kernel geometry is fixed
   localparam int KERN = 3;
   localparam logic [1:0] KMAX = 2'(KERN - 1);

   // Arithmetic widths
   localparam int ACT_W    = 16;
   localparam int WGT_W    = 8;
   localparam int WDIFF_W  = WGT_W + 1;
   localparam int PROD_W   = ACT_W + WDIFF_W;
   localparam int SCALE_W  = 16;
   localparam int FRAC     = 16;
   localparam int COORD_W  = 8;
   localparam int OUT_MAX  = 32767;
   localparam int OUT_MIN  = -32768;

   // Configuration port
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   localparam logic [2:0] REG_MAP_HEIGHT   = 3'd0;
   localparam logic [2:0] REG_MAP_WIDTH    = 3'd1;
   localparam logic [2:0] REG_IN_CHANNELS  = 3'd2;
   localparam logic [2:0] REG_OUT_CHANNELS = 3'd3;
   localparam logic [2:0] REG_WGT_OFFSET   = 3'd4;
   localparam logic [2:0] REG_SCALE        = 3'd5;

   // Command codes
   localparam logic [1:0] CMD_WRITE_WGT = 2'd0;
   localparam logic [1:0] CMD_WRITE_ACT = 2'd1;
   localparam logic [1:0] CMD_COMPUTE   = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [13:0]        store_index;
      logic signed [15:0] write_value;
      logic [3:0]         out_channel;
      logic [4:0]         out_row;
      logic [4:0]         out_col;
   } req_type;

   typedef struct packed {
      logic signed [15:0] output_value;
      logic               status;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       wr_wgt;
      logic       wr_act;
      logic       load;
      logic       check;
      logic       tap_setup;
      logic       issue;
      logic       scale;
      logic       emit;
      logic [1:0] kh;
      logic [1:0] kw;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_of_range;
   } dp_stat_type;

endpackage

// ----- hdl/conv2d_3x3_same_int8.sv -----
// Top level of the 3x3 same-padding int8 convolution: configuration port, sequencer, datapath.
// Depends on cnv_pkg, cnv_csr, cnv_ctrl and cnv_dp.
//
// A word is accepted when start is high and busy is low. Weight and activation writes never
// raise busy, so they can be issued every cycle while no compute is running. A compute word
// keeps busy high while it walks the nine taps and the input channels in use, and its
// result appears on rsp_data with rsp_valid high for exactly one cycle right after busy
// falls; a request outside the configured map or channel count gives status 1 without a
// walk. The compute time is set by the single multiply-accumulate unit, fed by one read port
// per store, which handles one tap of one input channel per cycle after a setup step per tap.
// Results cannot be held off; the stores need no clearing pass after reset, but an entry
// must be written before a compute reads it.
module conv2d_3x3_same_int8 #(
   parameter int MAX_HEIGHT       = cnv_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH        = cnv_pkg::DEF_MAX_WIDTH,
   parameter int MAX_IN_CHANNELS  = cnv_pkg::DEF_MAX_IN_CHANNELS,
   parameter int MAX_OUT_CHANNELS = cnv_pkg::DEF_MAX_OUT_CHANNELS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  cnv_pkg::req_type             req_data,
   output logic                         rsp_valid,
   output cnv_pkg::rsp_type             rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [cnv_pkg::CSR_AW-1:0]   paddr,
   input  logic [cnv_pkg::CSR_DW-1:0]   pwdata,
   output logic [cnv_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);

   logic [$clog2(MAX_HEIGHT+1)-1:0]       h_eff;
   logic [$clog2(MAX_WIDTH+1)-1:0]        w_eff;
   logic [$clog2(MAX_IN_CHANNELS+1)-1:0]  ci_eff;
   logic [$clog2(MAX_OUT_CHANNELS+1)-1:0] co_eff;
   logic [7:0]                            wgt_offset;
   logic [cnv_pkg::SCALE_W-1:0]           scale;
   cnv_pkg::ctrl_cmd_type                 cmd;
   cnv_pkg::dp_stat_type                  stat;

   cnv_csr #(
      .MAX_HEIGHT       (MAX_HEIGHT),
      .MAX_WIDTH        (MAX_WIDTH),
      .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
      .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .h_eff      (h_eff),
      .w_eff      (w_eff),
      .ci_eff     (ci_eff),
      .co_eff     (co_eff),
      .wgt_offset (wgt_offset),
      .scale      (scale)
   );

   cnv_ctrl #(
      .MAX_IN_CHANNELS (MAX_IN_CHANNELS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_data.cmd),
      .ci_eff  (ci_eff),
      .stat    (stat),
      .cmd     (cmd),
      .busy    (busy)
   );

   cnv_dp #(
      .MAX_HEIGHT       (MAX_HEIGHT),
      .MAX_WIDTH        (MAX_WIDTH),
      .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
      .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req_data),
      .h_eff      (h_eff),
      .w_eff      (w_eff),
      .ci_eff     (ci_eff),
      .co_eff     (co_eff),
      .wgt_offset (wgt_offset),
      .scale      (scale),
      .stat       (stat),
      .rsp        (rsp_data),
      .rsp_valid  (rsp_valid)
   );

   // A compute word occupies the block from the next cycle on
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == cnv_pkg::CMD_COMPUTE) |=> busy)
      else $error("compute word did not raise busy");

   // Store writes never occupy the block
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd != cnv_pkg::CMD_COMPUTE) |=> !busy)
      else $error("write word raised busy");

   // A result only closes a compute
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("result strobe outside the end of a compute");

   // One result per compute: strobes never come back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe repeated");

endmodule

// ----- hdl/cnv_csr.sv -----
// Configuration registers behind the APB-style port, with clamping to the build limits.
// Depends on cnv_pkg for register indexes and port widths.
module cnv_csr #(
   parameter int MAX_HEIGHT       = cnv_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH        = cnv_pkg::DEF_MAX_WIDTH,
   parameter int MAX_IN_CHANNELS  = cnv_pkg::DEF_MAX_IN_CHANNELS,
   parameter int MAX_OUT_CHANNELS = cnv_pkg::DEF_MAX_OUT_CHANNELS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       psel,
   input  logic                                       penable,
   input  logic                                       pwrite,
   input  logic [cnv_pkg::CSR_AW-1:0]                 paddr,
   input  logic [cnv_pkg::CSR_DW-1:0]                 pwdata,
   output logic [cnv_pkg::CSR_DW-1:0]                 prdata,
   output logic                                       pready,
   output logic [$clog2(MAX_HEIGHT+1)-1:0]            h_eff,
   output logic [$clog2(MAX_WIDTH+1)-1:0]             w_eff,
   output logic [$clog2(MAX_IN_CHANNELS+1)-1:0]       ci_eff,
   output logic [$clog2(MAX_OUT_CHANNELS+1)-1:0]      co_eff,
   output logic [7:0]                                 wgt_offset,
   output logic [cnv_pkg::SCALE_W-1:0]                scale
);

   localparam int H_W  = $clog2(MAX_HEIGHT+1);
   localparam int W_W  = $clog2(MAX_WIDTH+1);
   localparam int CI_W = $clog2(MAX_IN_CHANNELS+1);
   localparam int CO_W = $clog2(MAX_OUT_CHANNELS+1);

   logic [5:0]  map_height_ff, map_height_in;
   logic [5:0]  map_width_ff, map_width_in;
   logic [4:0]  in_channels_ff, in_channels_in;
   logic [4:0]  out_channels_ff, out_channels_in;
   logic [7:0]  wgt_offset_ff, wgt_offset_in;
   logic [15:0] scale_ff, scale_in;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];

   always_comb begin
      map_height_in   = map_height_ff;
      map_width_in    = map_width_ff;
      in_channels_in  = in_channels_ff;
      out_channels_in = out_channels_ff;
      wgt_offset_in   = wgt_offset_ff;
      scale_in        = scale_ff;
      if (wr_en) begin
         unique case (reg_idx)
            cnv_pkg::REG_MAP_HEIGHT:   map_height_in   = pwdata[5:0];
            cnv_pkg::REG_MAP_WIDTH:    map_width_in    = pwdata[5:0];
            cnv_pkg::REG_IN_CHANNELS:  in_channels_in  = pwdata[4:0];
            cnv_pkg::REG_OUT_CHANNELS: out_channels_in = pwdata[4:0];
            cnv_pkg::REG_WGT_OFFSET:   wgt_offset_in   = pwdata[7:0];
            cnv_pkg::REG_SCALE:        scale_in        = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_height_ff   <= 6'd28;
         map_width_ff    <= 6'd28;
         in_channels_ff  <= 5'd1;
         out_channels_ff <= 5'd8;
         wgt_offset_ff   <= 8'd0;
         scale_ff        <= 16'd256;
      end else begin
         map_height_ff   <= map_height_in;
         map_width_ff    <= map_width_in;
         in_channels_ff  <= in_channels_in;
         out_channels_ff <= out_channels_in;
         wgt_offset_ff   <= wgt_offset_in;
         scale_ff        <= scale_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         cnv_pkg::REG_MAP_HEIGHT:   prdata = 32'(map_height_ff);
         cnv_pkg::REG_MAP_WIDTH:    prdata = 32'(map_width_ff);
         cnv_pkg::REG_IN_CHANNELS:  prdata = 32'(in_channels_ff);
         cnv_pkg::REG_OUT_CHANNELS: prdata = 32'(out_channels_ff);
         cnv_pkg::REG_WGT_OFFSET:   prdata = 32'(wgt_offset_ff);
         cnv_pkg::REG_SCALE:        prdata = 32'(scale_ff);
         default:                   prdata = '0;
      endcase
   end

   // Values above a build limit act as the limit
   assign h_eff  = (32'(map_height_ff) > MAX_HEIGHT) ? H_W'(MAX_HEIGHT)
                                                     : H_W'(map_height_ff);
   assign w_eff  = (32'(map_width_ff) > MAX_WIDTH) ? W_W'(MAX_WIDTH)
                                                   : W_W'(map_width_ff);
   assign ci_eff = (32'(in_channels_ff) > MAX_IN_CHANNELS) ? CI_W'(MAX_IN_CHANNELS)
                                                           : CI_W'(in_channels_ff);
   assign co_eff = (32'(out_channels_ff) > MAX_OUT_CHANNELS) ? CO_W'(MAX_OUT_CHANNELS)
                                                             : CO_W'(out_channels_ff);
   assign wgt_offset = wgt_offset_ff;
   assign scale      = scale_ff;

endmodule

// ----- hdl/cnv_ctrl.sv -----
// Sequencer for the convolution: walks the nine taps and the input channels of each tap.
// Depends on cnv_pkg for the command and status structs and the command codes.
module cnv_ctrl #(
   parameter int MAX_IN_CHANNELS = cnv_pkg::DEF_MAX_IN_CHANNELS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [1:0]                            req_cmd,
   input  logic [$clog2(MAX_IN_CHANNELS+1)-1:0]  ci_eff,
   input  cnv_pkg::dp_stat_type                  stat,
   output cnv_pkg::ctrl_cmd_type                 cmd,
   output logic                                  busy
);

   localparam int CI_W = $clog2(MAX_IN_CHANNELS+1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_TAP, ST_ISSUE, ST_DRAIN1, ST_DRAIN2, ST_SCALE, ST_EMIT
   } state_type;

   state_type       state_ff;
   logic [1:0]      kh_ff;
   logic [1:0]      kw_ff;
   logic [CI_W-1:0] ic_ff;
   logic            last_tap;
   logic            last_ic;

   assign last_tap = (kh_ff == cnv_pkg::KMAX) && (kw_ff == cnv_pkg::KMAX);
   assign last_ic  = (ic_ff == ci_eff - CI_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kh_ff    <= '0;
         kw_ff    <= '0;
         ic_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start && req_cmd == cnv_pkg::CMD_COMPUTE) state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               kh_ff    <= '0;
               kw_ff    <= '0;
               ic_ff    <= '0;
               state_ff <= stat.out_of_range ? ST_EMIT : ST_TAP;
            end
            ST_TAP: begin
               ic_ff <= '0;
               if (ci_eff != '0) begin
                  state_ff <= ST_ISSUE;
               end else if (last_tap) begin
                  state_ff <= ST_DRAIN1;
               end else begin
                  // no channels: skip straight to the next tap
                  kw_ff <= (kw_ff == cnv_pkg::KMAX) ? 2'd0 : kw_ff + 2'd1;
                  kh_ff <= (kw_ff == cnv_pkg::KMAX) ? kh_ff + 2'd1 : kh_ff;
               end
            end
            ST_ISSUE: begin
               if (!last_ic) begin
                  ic_ff <= ic_ff + CI_W'(1);
               end else if (last_tap) begin
                  state_ff <= ST_DRAIN1;
               end else begin
                  kw_ff    <= (kw_ff == cnv_pkg::KMAX) ? 2'd0 : kw_ff + 2'd1;
                  kh_ff    <= (kw_ff == cnv_pkg::KMAX) ? kh_ff + 2'd1 : kh_ff;
                  state_ff <= ST_TAP;
               end
            end
            // let the read, multiply and accumulate stages empty
            ST_DRAIN1: state_ff <= ST_DRAIN2;
            ST_DRAIN2: state_ff <= ST_SCALE;
            ST_SCALE:  state_ff <= ST_EMIT;
            ST_EMIT:   state_ff <= ST_IDLE;
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.wr_wgt    = (state_ff == ST_IDLE) && start && (req_cmd == cnv_pkg::CMD_WRITE_WGT);
      cmd.wr_act    = (state_ff == ST_IDLE) && start && (req_cmd == cnv_pkg::CMD_WRITE_ACT);
      cmd.load      = (state_ff == ST_IDLE) && start && (req_cmd == cnv_pkg::CMD_COMPUTE);
      cmd.check     = (state_ff == ST_CHECK);
      cmd.tap_setup = (state_ff == ST_TAP);
      cmd.issue     = (state_ff == ST_ISSUE);
      cmd.scale     = (state_ff == ST_SCALE);
      cmd.emit      = (state_ff == ST_EMIT);
      cmd.kh        = kh_ff;
      cmd.kw        = kw_ff;
   end

endmodule

// ----- hdl/cnv_dp.sv -----
// Datapath: weight and activation stores, address walk, multiply-accumulate, scale and saturate.
// Depends on cnv_pkg for the payload, command and status types and arithmetic widths.
module cnv_dp #(
   parameter int MAX_HEIGHT       = cnv_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH        = cnv_pkg::DEF_MAX_WIDTH,
   parameter int MAX_IN_CHANNELS  = cnv_pkg::DEF_MAX_IN_CHANNELS,
   parameter int MAX_OUT_CHANNELS = cnv_pkg::DEF_MAX_OUT_CHANNELS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cnv_pkg::ctrl_cmd_type                  cmd,
   input  cnv_pkg::req_type                       req,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]        h_eff,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]         w_eff,
   input  logic [$clog2(MAX_IN_CHANNELS+1)-1:0]   ci_eff,
   input  logic [$clog2(MAX_OUT_CHANNELS+1)-1:0]  co_eff,
   input  logic [7:0]                             wgt_offset,
   input  logic [cnv_pkg::SCALE_W-1:0]            scale,
   output cnv_pkg::dp_stat_type                   stat,
   output cnv_pkg::rsp_type                       rsp,
   output logic                                   rsp_valid
);

   localparam int ACT_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
   localparam int ACT_AW    = $clog2(ACT_DEPTH);
   localparam int WGT_DEPTH = MAX_OUT_CHANNELS * cnv_pkg::KERN * cnv_pkg::KERN
                              * MAX_IN_CHANNELS;
   localparam int WGT_AW    = $clog2(WGT_DEPTH);
   localparam int PLANE_W   = $clog2(MAX_HEIGHT * MAX_WIDTH + 1);
   localparam int ACC_W     = cnv_pkg::PROD_W
                              + $clog2(cnv_pkg::KERN * cnv_pkg::KERN * MAX_IN_CHANNELS);
   localparam int SC_W      = ACC_W + cnv_pkg::SCALE_W + 1;
   localparam int SH_W      = SC_W - cnv_pkg::FRAC;
   localparam int CW        = cnv_pkg::COORD_W;

   logic signed [cnv_pkg::ACT_W-1:0] act_mem [ACT_DEPTH];
   logic [cnv_pkg::WGT_W-1:0]        wgt_mem [WGT_DEPTH];

   logic [3:0]                         oc_ff;
   logic [4:0]                         oh_ff;
   logic [4:0]                         ow_ff;
   logic [PLANE_W-1:0]                 plane_ff;
   logic [ACT_AW-1:0]                  act_addr_ff;
   logic [WGT_AW-1:0]                  wgt_addr_ff;
   logic                               tap_ok_ff;
   logic                               v1_ff;
   logic                               v2_ff;
   logic signed [cnv_pkg::ACT_W-1:0]   act_rd_ff;
   logic [cnv_pkg::WGT_W-1:0]          wgt_rd_ff;
   logic signed [cnv_pkg::PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]            acc_ff;
   logic signed [SC_W-1:0]             scaled_ff;
   cnv_pkg::rsp_type                   rsp_ff;
   logic                               rsp_valid_ff;

   logic signed [CW-1:0]               row_s;
   logic signed [CW-1:0]               col_s;
   logic signed [2*CW-1:0]             base_s;
   logic                               tap_ok;
   logic signed [cnv_pkg::WDIFF_W-1:0] wdiff;
   logic signed [cnv_pkg::PROD_W-1:0]  mac_prod;
   logic signed [SH_W-1:0]             shifted;
   logic signed [15:0]                 sat_value;

   // Store writes; addresses beyond a store are dropped
   always_ff @(posedge clock) begin
      if (cmd.wr_act && (32'(req.store_index) < ACT_DEPTH))
         act_mem[ACT_AW'(req.store_index)] <= req.write_value;
      act_rd_ff <= act_mem[act_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_wgt && (32'(req.store_index) < WGT_DEPTH))
         wgt_mem[WGT_AW'(req.store_index)] <= req.write_value[7:0];
      wgt_rd_ff <= wgt_mem[wgt_addr_ff];
   end

   assign stat.out_of_range = (32'(oc_ff) >= 32'(co_eff)) ||
                              (32'(oh_ff) >= 32'(h_eff)) ||
                              (32'(ow_ff) >= 32'(w_eff));

   // Input position of the current tap, one row and column of padding
   assign row_s  = $signed(CW'(oh_ff)) + $signed(CW'(cmd.kh)) - $signed(CW'(1));
   assign col_s  = $signed(CW'(ow_ff)) + $signed(CW'(cmd.kw)) - $signed(CW'(1));
   assign tap_ok = (row_s >= 0) && (row_s < $signed(CW'(h_eff))) &&
                   (col_s >= 0) && (col_s < $signed(CW'(w_eff)));
   assign base_s = row_s * $signed(CW'(w_eff)) + col_s;

   assign wdiff    = $signed({wgt_rd_ff[7], wgt_rd_ff}) - $signed({wgt_offset[7], wgt_offset});
   assign mac_prod = act_rd_ff * wdiff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         oc_ff <= req.out_channel;
         oh_ff <= req.out_row;
         ow_ff <= req.out_col;
      end
      if (cmd.check) begin
         plane_ff    <= PLANE_W'(h_eff * w_eff);
         wgt_addr_ff <= WGT_AW'(oc_ff * ci_eff * (cnv_pkg::KERN * cnv_pkg::KERN));
      end else if (cmd.issue) begin
         wgt_addr_ff <= wgt_addr_ff + WGT_AW'(1);
      end
      if (cmd.tap_setup) begin
         act_addr_ff <= ACT_AW'(base_s);
         tap_ok_ff   <= tap_ok;
      end else if (cmd.issue) begin
         // advance to the same position in the next channel plane
         act_addr_ff <= act_addr_ff + ACT_AW'(plane_ff);
      end
      prod_ff <= v1_ff ? mac_prod : '0;
      if (cmd.check)
         acc_ff <= '0;
      else if (v2_ff)
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      if (cmd.scale)
         scaled_ff <= acc_ff * $signed({1'b0, scale});
   end

   // Arithmetic shift rounds toward minus infinity
   assign shifted = $signed(scaled_ff[SC_W-1:cnv_pkg::FRAC]);

   always_comb begin
      if (shifted > SH_W'(cnv_pkg::OUT_MAX))
         sat_value = 16'(cnv_pkg::OUT_MAX);
      else if (shifted < SH_W'(cnv_pkg::OUT_MIN))
         sat_value = 16'(cnv_pkg::OUT_MIN);
      else
         sat_value = shifted[15:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.status       <= stat.out_of_range;
         rsp_ff.output_value <= stat.out_of_range ? 16'sd0 : sat_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= cmd.issue & tap_ok_ff;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule
